// ===== hw/rtl/rds_pkg.sv =====
// Shared types and constants for the reliable delivery sequencer.
// No dependencies; used by rds_front, rds_back and the top level.
package rds_pkg;

    // Default sizes of the outbox, retained inbox and dedupe table
    localparam int OUTBOX_DEPTH_DEF = 8;
    localparam int INBOX_DEPTH_DEF  = 20;
    localparam int SEEN_DEPTH_DEF   = 32;

    localparam logic [31:0] SEQ_MAX           = 32'hFFFF_FFFF;
    localparam logic [63:0] LOCAL_EPOCH_RESET = 64'd1;

    // Function codes on the func input
    localparam logic [2:0] FUNC_SUBMIT     = 3'd0;
    localparam logic [2:0] FUNC_RECEIPT    = 3'd1;
    localparam logic [2:0] FUNC_DATA       = 3'd2;
    localparam logic [2:0] FUNC_CANCEL     = 3'd3;
    localparam logic [2:0] FUNC_CANCEL_ALL = 3'd4;

    // Result status codes
    localparam logic [3:0] ST_QUEUED     = 4'd0;
    localparam logic [3:0] ST_REQUEUE    = 4'd1;
    localparam logic [3:0] ST_COLLISION  = 4'd2;
    localparam logic [3:0] ST_OUTBOX_FULL = 4'd3;
    localparam logic [3:0] ST_IGNORED    = 4'd4;
    localparam logic [3:0] ST_DELIVERED  = 4'd5;
    localparam logic [3:0] ST_DUPLICATE  = 4'd6;
    localparam logic [3:0] ST_STORED     = 4'd7;
    localparam logic [3:0] ST_DEDUPE_FULL = 4'd8;
    localparam logic [3:0] ST_CANCELED   = 4'd9;

    // Classified operation
    typedef enum logic [2:0] {
        OP_SUBMIT,
        OP_RECEIPT,
        OP_DATA,
        OP_CANCEL,
        OP_CANCEL_ALL,
        OP_NONE
    } op_t;

    // One classified request from the front to the back
    typedef struct packed {
        op_t         op;
        logic [31:0] msg_id;
        logic [31:0] peer_node;
        logic [63:0] frame_epoch;
        logic [31:0] frame_seq;
        logic [31:0] content_digest;
    } req_t;

    // One result item
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] assigned_seq;
        logic        send_receipt;
        logic        inbox_evicted;
        logic [3:0]  pending_count;
        logic [4:0]  retained_count;
        logic        head_valid;
        logic [31:0] head_msg_id;
        logic [31:0] head_seq;
    } res_t;

endpackage

// ===== hw/rtl/reliable_delivery_sequencer.sv =====
// Reliable delivery sequencer: one request in, one result out, queue ports.
// The back end scans or shifts the outbox one entry at a time, and scans the
// dedupe table one entry at a time (submit, cancel and data frames visit at
// least one entry). An unpopped result stalls the back end.
// The back end takes no new request until it is through with the last one.
// Reset clears counts and queues at once; memories need no clearing pass.
// Depends on rds_pkg, rds_front and rds_back.
module reliable_delivery_sequencer #(
    parameter int OUTBOX_DEPTH = rds_pkg::OUTBOX_DEPTH_DEF,
    parameter int INBOX_DEPTH  = rds_pkg::INBOX_DEPTH_DEF,
    parameter int SEEN_DEPTH   = rds_pkg::SEEN_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  func,
    input  logic [31:0] msg_id,
    input  logic [31:0] peer_node,
    input  logic [63:0] frame_epoch,
    input  logic [31:0] frame_seq,
    input  logic [31:0] content_digest,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  status,
    output logic [31:0] assigned_seq,
    output logic        send_receipt,
    output logic        inbox_evicted,
    output logic [3:0]  pending_count,
    output logic [4:0]  retained_count,
    output logic        head_valid,
    output logic [31:0] head_msg_id,
    output logic [31:0] head_seq
);

    logic          req_valid;
    rds_pkg::req_t req;
    logic          req_pop;
    logic          res_valid;
    rds_pkg::res_t res;

    // Accept and classify requests
    rds_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .msg_id         (msg_id),
        .peer_node      (peer_node),
        .frame_epoch    (frame_epoch),
        .frame_seq      (frame_seq),
        .content_digest (content_digest),
        .req_valid      (req_valid),
        .req            (req),
        .req_pop        (req_pop)
    );

    // Carry out requests
    rds_back #(
        .OUTBOX_DEPTH (OUTBOX_DEPTH),
        .INBOX_DEPTH  (INBOX_DEPTH),
        .SEEN_DEPTH   (SEEN_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req         (req),
        .req_pop     (req_pop),
        .res_valid   (res_valid),
        .res         (res),
        .res_pop     (pop)
    );

    assign empty          = !res_valid;
    assign status         = res.status;
    assign assigned_seq   = res.assigned_seq;
    assign send_receipt   = res.send_receipt;
    assign inbox_evicted  = res.inbox_evicted;
    assign pending_count  = res.pending_count;
    assign retained_count = res.retained_count;
    assign head_valid     = res.head_valid;
    assign head_msg_id    = res.head_msg_id;
    assign head_seq       = res.head_seq;

endmodule

// ===== hw/rtl/rds_front.sv =====
// Front end: accepts requests, classifies func and holds them in a
// two-entry queue for the back end. Depends on rds_pkg.
module rds_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         func,
    input  logic [31:0]        msg_id,
    input  logic [31:0]        peer_node,
    input  logic [63:0]        frame_epoch,
    input  logic [31:0]        frame_seq,
    input  logic [31:0]        content_digest,
    output logic               req_valid,
    output rds_pkg::req_t      req,
    input  logic               req_pop
);

    rds_pkg::req_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    rds_pkg::req_t in_req;
    logic          do_push;
    logic          do_pop;

    // Classify the incoming request
    always_comb
    begin
        in_req.msg_id         = msg_id;
        in_req.peer_node      = peer_node;
        in_req.frame_epoch    = frame_epoch;
        in_req.frame_seq      = frame_seq;
        in_req.content_digest = content_digest;
        case (func)
            rds_pkg::FUNC_SUBMIT:     in_req.op = rds_pkg::OP_SUBMIT;
            rds_pkg::FUNC_RECEIPT:    in_req.op = rds_pkg::OP_RECEIPT;
            rds_pkg::FUNC_DATA:       in_req.op = rds_pkg::OP_DATA;
            rds_pkg::FUNC_CANCEL:     in_req.op = rds_pkg::OP_CANCEL;
            rds_pkg::FUNC_CANCEL_ALL: in_req.op = rds_pkg::OP_CANCEL_ALL;
            default:                  in_req.op = rds_pkg::OP_NONE;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_pop && req_valid;

    // Hold queue payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== hw/rtl/rds_back.sv =====
// Back end: runs one request at a time over the outbox and dedupe table
// memories and holds the result register. Depends on rds_pkg.
module rds_back #(
    parameter int OUTBOX_DEPTH = rds_pkg::OUTBOX_DEPTH_DEF,
    parameter int INBOX_DEPTH  = rds_pkg::INBOX_DEPTH_DEF,
    parameter int SEEN_DEPTH   = rds_pkg::SEEN_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [63:0]   cfg_wr_data,
    input  logic          req_valid,
    input  rds_pkg::req_t req,
    output logic          req_pop,
    output logic          res_valid,
    output rds_pkg::res_t res,
    input  logic          res_pop
);

    localparam int OB_AW = (OUTBOX_DEPTH > 1) ? $clog2(OUTBOX_DEPTH) : 1;
    localparam int OB_CW = $clog2(OUTBOX_DEPTH + 1);
    localparam int SN_AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int SN_CW = $clog2(SEEN_DEPTH + 1);
    localparam int IB_CW = $clog2(INBOX_DEPTH + 1);

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] dest;
        logic [31:0] digest;
    } ob_row_t;

    typedef struct packed {
        logic [31:0] sender;
        logic [63:0] epoch;
        logic [31:0] seq;
    } sn_row_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OB_SCAN,
        S_OB_SHIFT,
        S_SEEN_SCAN,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    rds_pkg::req_t req_reg, req_next;
    logic [63:0]   epoch_reg;
    logic [OB_CW-1:0] ob_count_reg, ob_count_next;
    logic [OB_AW-1:0] ob_idx_reg, ob_idx_next;
    logic [SN_CW-1:0] sn_count_reg, sn_count_next;
    logic [SN_AW-1:0] sn_idx_reg, sn_idx_next;
    logic [IB_CW-1:0] ib_count_reg, ib_count_next;
    logic [31:0]   next_seq_reg, next_seq_next;
    logic [31:0]   head_id_reg, head_id_next;
    logic [31:0]   head_seq_reg, head_seq_next;
    logic [3:0]    stat_reg, stat_next;
    logic [31:0]   aseq_reg, aseq_next;
    logic          rcpt_reg, rcpt_next;
    logic          evict_reg, evict_next;
    logic          res_valid_reg, res_valid_next;
    rds_pkg::res_t res_reg, res_next;

    ob_row_t       ob_mem [OUTBOX_DEPTH];
    ob_row_t       ob_rdata_reg;
    logic          ob_we;
    logic [OB_AW-1:0] ob_waddr;
    ob_row_t       ob_wdata;

    sn_row_t       sn_mem [SEEN_DEPTH];
    sn_row_t       sn_rdata_reg;
    logic          sn_we;
    logic [SN_AW-1:0] sn_waddr;
    sn_row_t       sn_wdata;

    logic          ob_hit;
    logic          ob_last;
    logic          sn_hit;
    logic          sn_last;

    // Outbox memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ob_we)
        begin
            ob_mem[ob_waddr] <= ob_wdata;
        end
        ob_rdata_reg <= ob_mem[ob_idx_next];
    end

    // Dedupe table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (sn_we)
        begin
            sn_mem[sn_waddr] <= sn_wdata;
        end
        sn_rdata_reg <= sn_mem[sn_idx_next];
    end

    // Hold the local epoch register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= rds_pkg::LOCAL_EPOCH_RESET;
        end
        else if (cfg_wr_en)
        begin
            epoch_reg <= cfg_wr_data;
        end
    end

    assign ob_hit  = (ob_count_reg != '0) && (ob_rdata_reg.id == req_reg.msg_id);
    assign ob_last = (ob_count_reg == '0) || (OB_CW'(ob_idx_reg) + 1'b1 == ob_count_reg);
    assign sn_hit  = (sn_count_reg != '0) && (sn_rdata_reg.sender == req_reg.peer_node)
                     && (sn_rdata_reg.epoch == req_reg.frame_epoch);
    assign sn_last = (sn_count_reg == '0) || (SN_CW'(sn_idx_reg) + 1'b1 == sn_count_reg);

    // Sequence the request
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        ob_count_next  = ob_count_reg;
        ob_idx_next    = ob_idx_reg;
        sn_count_next  = sn_count_reg;
        sn_idx_next    = sn_idx_reg;
        ib_count_next  = ib_count_reg;
        next_seq_next  = next_seq_reg;
        head_id_next   = head_id_reg;
        head_seq_next  = head_seq_reg;
        stat_next      = stat_reg;
        aseq_next      = aseq_reg;
        rcpt_next      = rcpt_reg;
        evict_next     = evict_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        req_pop        = 1'b0;
        ob_we          = 1'b0;
        ob_waddr       = ob_idx_reg;
        ob_wdata       = ob_rdata_reg;
        sn_we          = 1'b0;
        sn_waddr       = sn_idx_reg;
        sn_wdata       = sn_rdata_reg;

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop     = 1'b1;
                    req_next    = req;
                    aseq_next   = '0;
                    rcpt_next   = 1'b0;
                    evict_next  = 1'b0;
                    ob_idx_next = '0;
                    sn_idx_next = '0;
                    case (req.op)
                        rds_pkg::OP_SUBMIT, rds_pkg::OP_CANCEL:
                        begin
                            state_next = S_OB_SCAN;
                        end
                        rds_pkg::OP_RECEIPT:
                        begin
                            if ((ob_count_reg != '0) && (req.frame_epoch == epoch_reg)
                                && (req.frame_seq == head_seq_reg)
                                && (req.msg_id == head_id_reg))
                            begin
                                stat_next = rds_pkg::ST_DELIVERED;
                                if (ob_count_reg == OB_CW'(1))
                                begin
                                    ob_count_next = '0;
                                    state_next    = S_DONE;
                                end
                                else
                                begin
                                    ob_idx_next = OB_AW'(1);
                                    state_next  = S_OB_SHIFT;
                                end
                            end
                            else
                            begin
                                stat_next  = rds_pkg::ST_IGNORED;
                                state_next = S_DONE;
                            end
                        end
                        rds_pkg::OP_DATA:
                        begin
                            state_next = S_SEEN_SCAN;
                        end
                        rds_pkg::OP_CANCEL_ALL:
                        begin
                            ob_count_next = '0;
                            stat_next     = rds_pkg::ST_CANCELED;
                            state_next    = S_DONE;
                        end
                        default:
                        begin
                            stat_next  = rds_pkg::ST_IGNORED;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_OB_SCAN:
            begin
                if (ob_hit)
                begin
                    if (req_reg.op == rds_pkg::OP_SUBMIT)
                    begin
                        stat_next = ((ob_rdata_reg.dest == req_reg.peer_node)
                                     && (ob_rdata_reg.digest == req_reg.content_digest))
                                    ? rds_pkg::ST_REQUEUE : rds_pkg::ST_COLLISION;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Drop the matching entry
                        stat_next = rds_pkg::ST_CANCELED;
                        if (ob_last)
                        begin
                            ob_count_next = ob_count_reg - 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            ob_idx_next = ob_idx_reg + 1'b1;
                            state_next  = S_OB_SHIFT;
                        end
                    end
                end
                else if (ob_last)
                begin
                    if (req_reg.op == rds_pkg::OP_SUBMIT)
                    begin
                        if ((ob_count_reg == OB_CW'(OUTBOX_DEPTH))
                            || (next_seq_reg == rds_pkg::SEQ_MAX))
                        begin
                            stat_next = rds_pkg::ST_OUTBOX_FULL;
                        end
                        else
                        begin
                            // Append at the tail
                            ob_we           = 1'b1;
                            ob_waddr        = OB_AW'(ob_count_reg);
                            ob_wdata.id     = req_reg.msg_id;
                            ob_wdata.seq    = next_seq_reg;
                            ob_wdata.dest   = req_reg.peer_node;
                            ob_wdata.digest = req_reg.content_digest;
                            if (ob_count_reg == '0)
                            begin
                                head_id_next  = req_reg.msg_id;
                                head_seq_next = next_seq_reg;
                            end
                            ob_count_next = ob_count_reg + 1'b1;
                            aseq_next     = next_seq_reg;
                            next_seq_next = next_seq_reg + 32'd1;
                            stat_next     = rds_pkg::ST_QUEUED;
                        end
                    end
                    else
                    begin
                        stat_next = rds_pkg::ST_CANCELED;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    ob_idx_next = ob_idx_reg + 1'b1;
                end
            end

            S_OB_SHIFT:
            begin
                // Move entry down one place
                ob_we    = 1'b1;
                ob_waddr = ob_idx_reg - 1'b1;
                ob_wdata = ob_rdata_reg;
                if (ob_idx_reg == OB_AW'(1))
                begin
                    head_id_next  = ob_rdata_reg.id;
                    head_seq_next = ob_rdata_reg.seq;
                end
                if (ob_last)
                begin
                    ob_count_next = ob_count_reg - 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    ob_idx_next = ob_idx_reg + 1'b1;
                end
            end

            S_SEEN_SCAN:
            begin
                if (sn_hit && (req_reg.frame_seq <= sn_rdata_reg.seq))
                begin
                    stat_next  = rds_pkg::ST_DUPLICATE;
                    rcpt_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (!sn_hit && sn_last && (sn_count_reg >= SN_CW'(SEEN_DEPTH)))
                begin
                    stat_next  = rds_pkg::ST_DEDUPE_FULL;
                    state_next = S_DONE;
                end
                else if (sn_hit || sn_last)
                begin
                    // Record the high-water mark and retain the frame
                    sn_we           = 1'b1;
                    sn_wdata.sender = req_reg.peer_node;
                    sn_wdata.epoch  = req_reg.frame_epoch;
                    sn_wdata.seq    = req_reg.frame_seq;
                    if (sn_hit)
                    begin
                        sn_waddr = sn_idx_reg;
                    end
                    else
                    begin
                        sn_waddr      = SN_AW'(sn_count_reg);
                        sn_count_next = sn_count_reg + 1'b1;
                    end
                    if (ib_count_reg >= IB_CW'(INBOX_DEPTH))
                    begin
                        evict_next = 1'b1;
                    end
                    else
                    begin
                        ib_count_next = ib_count_reg + 1'b1;
                    end
                    stat_next  = rds_pkg::ST_STORED;
                    rcpt_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    sn_idx_next = sn_idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_next.status         = stat_reg;
                    res_next.assigned_seq   = aseq_reg;
                    res_next.send_receipt   = rcpt_reg;
                    res_next.inbox_evicted  = evict_reg;
                    res_next.pending_count  = 4'(ob_count_reg);
                    res_next.retained_count = 5'(ib_count_reg);
                    res_next.head_valid     = (ob_count_reg != '0);
                    res_next.head_msg_id    = (ob_count_reg != '0) ? head_id_reg : 32'd0;
                    res_next.head_seq       = (ob_count_reg != '0) ? head_seq_reg : 32'd0;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ob_count_reg  <= '0;
            ob_idx_reg    <= '0;
            sn_count_reg  <= '0;
            sn_idx_reg    <= '0;
            ib_count_reg  <= '0;
            next_seq_reg  <= 32'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ob_count_reg  <= ob_count_next;
            ob_idx_reg    <= ob_idx_next;
            sn_count_reg  <= sn_count_next;
            sn_idx_reg    <= sn_idx_next;
            ib_count_reg  <= ib_count_next;
            next_seq_reg  <= next_seq_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        head_id_reg  <= head_id_next;
        head_seq_reg <= head_seq_next;
        stat_reg     <= stat_next;
        aseq_reg     <= aseq_next;
        rcpt_reg     <= rcpt_next;
        evict_reg    <= evict_next;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ob_count_reg <= OB_CW'(OUTBOX_DEPTH))
        else $error("outbox count beyond depth");
    a_sn_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sn_count_reg <= SN_CW'(SEEN_DEPTH))
        else $error("dedupe count beyond depth");
    a_ib_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ib_count_reg <= IB_CW'(INBOX_DEPTH))
        else $error("inbox count beyond depth");
    a_seq_nz: assert property (@(posedge clk) disable iff (!rst_n)
        next_seq_reg != 32'd0)
        else $error("sequence counter wrapped");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> (state_reg == S_IDLE))
        else $error("request taken while busy");
`endif

endmodule

// ===== tb/sv/reliable_delivery_sequencer_tb.sv =====
// Self-checking testbench for the reliable delivery sequencer.
// Depends on rds_pkg and the reliable_delivery_sequencer top level.
module reliable_delivery_sequencer_tb;

    localparam int          OUTBOX_N    = 8;
    localparam int          INBOX_N     = 20;
    localparam int          SEEN_N      = 32;
    localparam logic [2:0]  FUNC_UNUSED = 3'd5;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 50;

    typedef struct {
        logic [31:0] id;
        logic [31:0] seq;
        logic [31:0] dest;
        logic [31:0] digest;
    } outbox_entry_t;

    typedef struct {
        logic [31:0] sender;
        logic [63:0] epoch;
        logic [31:0] seq;
    } seen_entry_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [63:0] cfg_wr_data;
    logic        push;
    logic        full;
    logic [2:0]  func;
    logic [31:0] msg_id;
    logic [31:0] peer_node;
    logic [63:0] frame_epoch;
    logic [31:0] frame_seq;
    logic [31:0] content_digest;
    logic        empty;
    logic        pop;
    logic [3:0]  status;
    logic [31:0] assigned_seq;
    logic        send_receipt;
    logic        inbox_evicted;
    logic [3:0]  pending_count;
    logic [4:0]  retained_count;
    logic        head_valid;
    logic [31:0] head_msg_id;
    logic [31:0] head_seq;

    // Predictor state
    outbox_entry_t outbox_q[$];
    seen_entry_t   seen_q[$];
    logic [31:0]   inbox_q[$];
    logic [31:0]   seq_counter;
    logic [63:0]   epoch_reg;

    rds_pkg::res_t expected_results[$];
    int   error_count;
    int   cycle_count;
    int   hold_cnt;
    int   pop_stall;
    bit   no_idle;

    reliable_delivery_sequencer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .push           (push),
        .full           (full),
        .func           (func),
        .msg_id         (msg_id),
        .peer_node      (peer_node),
        .frame_epoch    (frame_epoch),
        .frame_seq      (frame_seq),
        .content_digest (content_digest),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .assigned_seq   (assigned_seq),
        .send_receipt   (send_receipt),
        .inbox_evicted  (inbox_evicted),
        .pending_count  (pending_count),
        .retained_count (retained_count),
        .head_valid     (head_valid),
        .head_msg_id    (head_msg_id),
        .head_seq       (head_seq)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Count down a long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Compute the result of one accepted request and advance the state
    function automatic rds_pkg::res_t predict_result(logic [2:0] f, logic [31:0] id,
                                                     logic [31:0] peer, logic [63:0] ep,
                                                     logic [31:0] sq, logic [31:0] dig);
        rds_pkg::res_t r;
        outbox_entry_t ob;
        seen_entry_t   se;
        int            idx;
        bit            found;
        r = '0;
        r.status = rds_pkg::ST_IGNORED;
        found = 0;
        case (f)
            rds_pkg::FUNC_SUBMIT:
            begin
                foreach (outbox_q[i])
                begin
                    if (!found && outbox_q[i].id == id)
                    begin
                        found = 1;
                        r.status = (outbox_q[i].dest == peer && outbox_q[i].digest == dig)
                                   ? rds_pkg::ST_REQUEUE : rds_pkg::ST_COLLISION;
                    end
                end
                if (!found)
                begin
                    if (outbox_q.size() >= OUTBOX_N || seq_counter == rds_pkg::SEQ_MAX)
                        r.status = rds_pkg::ST_OUTBOX_FULL;
                    else
                    begin
                        ob.id = id;
                        ob.seq = seq_counter;
                        ob.dest = peer;
                        ob.digest = dig;
                        outbox_q.push_back(ob);
                        r.assigned_seq = seq_counter;
                        seq_counter = seq_counter + 32'd1;
                        r.status = rds_pkg::ST_QUEUED;
                    end
                end
            end
            rds_pkg::FUNC_RECEIPT:
            begin
                if (outbox_q.size() > 0 && ep == epoch_reg && sq == outbox_q[0].seq
                    && id == outbox_q[0].id)
                begin
                    void'(outbox_q.pop_front());
                    r.status = rds_pkg::ST_DELIVERED;
                end
            end
            rds_pkg::FUNC_DATA:
            begin
                idx = -1;
                foreach (seen_q[i])
                begin
                    if (idx < 0 && seen_q[i].sender == peer && seen_q[i].epoch == ep)
                        idx = i;
                end
                if (idx >= 0 && sq <= seen_q[idx].seq)
                begin
                    r.status = rds_pkg::ST_DUPLICATE;
                    r.send_receipt = 1'b1;
                end
                else if (idx < 0 && seen_q.size() >= SEEN_N)
                    r.status = rds_pkg::ST_DEDUPE_FULL;
                else
                begin
                    if (idx < 0)
                    begin
                        se.sender = peer;
                        se.epoch = ep;
                        se.seq = sq;
                        seen_q.push_back(se);
                    end
                    else
                        seen_q[idx].seq = sq;
                    if (inbox_q.size() >= INBOX_N)
                    begin
                        void'(inbox_q.pop_front());
                        r.inbox_evicted = 1'b1;
                    end
                    inbox_q.push_back(id);
                    r.status = rds_pkg::ST_STORED;
                    r.send_receipt = 1'b1;
                end
            end
            rds_pkg::FUNC_CANCEL:
            begin
                idx = -1;
                foreach (outbox_q[i])
                begin
                    if (idx < 0 && outbox_q[i].id == id)
                        idx = i;
                end
                if (idx >= 0)
                    outbox_q.delete(idx);
                r.status = rds_pkg::ST_CANCELED;
            end
            rds_pkg::FUNC_CANCEL_ALL:
            begin
                outbox_q.delete();
                r.status = rds_pkg::ST_CANCELED;
            end
            default:
                r.status = rds_pkg::ST_IGNORED;
        endcase
        r.pending_count = 4'(outbox_q.size());
        r.retained_count = 5'(inbox_q.size());
        r.head_valid = outbox_q.size() > 0;
        if (outbox_q.size() > 0)
        begin
            r.head_msg_id = outbox_q[0].id;
            r.head_seq = outbox_q[0].seq;
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its result
    task automatic send_request(logic [2:0] f, logic [31:0] id, logic [31:0] peer,
                                logic [63:0] ep, logic [31:0] sq, logic [31:0] dig);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= f;
        msg_id <= id;
        peer_node <= peer;
        frame_epoch <= ep;
        frame_seq <= sq;
        content_digest <= dig;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        expected_results.push_back(predict_result(f, id, peer, ep, sq, dig));
    endtask

    // Drop push and wait until every result is back and the block is quiet
    task automatic drain();
        push <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_epoch(logic [63:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        epoch_reg = value;
    endtask

    // Check each popped result against the oldest expectation
    always @(posedge clk)
    begin
        rds_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
                report("unexpected result", 64'(status), 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report("status", 64'(status), 64'(want.status));
                if (assigned_seq !== want.assigned_seq)
                    report("assigned_seq", 64'(assigned_seq), 64'(want.assigned_seq));
                if (send_receipt !== want.send_receipt)
                    report("send_receipt", 64'(send_receipt), 64'(want.send_receipt));
                if (inbox_evicted !== want.inbox_evicted)
                    report("inbox_evicted", 64'(inbox_evicted), 64'(want.inbox_evicted));
                if (pending_count !== want.pending_count)
                    report("pending_count", 64'(pending_count), 64'(want.pending_count));
                if (retained_count !== want.retained_count)
                    report("retained_count", 64'(retained_count),
                           64'(want.retained_count));
                if (head_valid !== want.head_valid)
                    report("head_valid", 64'(head_valid), 64'(want.head_valid));
                if (head_msg_id !== want.head_msg_id)
                    report("head_msg_id", 64'(head_msg_id), 64'(want.head_msg_id));
                if (head_seq !== want.head_seq)
                    report("head_seq", 64'(head_seq), 64'(want.head_seq));
            end
        end
        // Stall the receiver at random, or hold off entirely
        if (hold_cnt > 0)
            pop <= 1'b0;
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall <= pop_stall - 1;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            pop <= 1'b0;
            pop_stall <= pick_gap();
        end
        else
            pop <= 1'b1;
    end

    function automatic logic [31:0] rand_word32();
        return $urandom;
    endfunction

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_submit();
        send_request(rds_pkg::FUNC_SUBMIT, 32'h0, 32'h0, '0, '0, 32'h0);
        send_request(rds_pkg::FUNC_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1,
                     32'hFFFF_FFFF);
        // requeue, then collisions on destination and on digest
        send_request(rds_pkg::FUNC_SUBMIT, 32'h0, 32'h0, '0, '0, 32'h0);
        send_request(rds_pkg::FUNC_SUBMIT, 32'h0, 32'h1, '0, '0, 32'h0);
        send_request(rds_pkg::FUNC_SUBMIT, 32'h0, 32'h0, '0, '0, 32'h1);
        // fill the outbox and go past it
        for (int i = 1; i <= OUTBOX_N - 1; i++)
            send_request(rds_pkg::FUNC_SUBMIT, i, 32'h5, '0, '0, i);
    endtask

    task automatic test_receipt();
        send_request(rds_pkg::FUNC_RECEIPT, outbox_q[0].id, 0, epoch_reg + 64'd1,
                     outbox_q[0].seq, 0);
        send_request(rds_pkg::FUNC_RECEIPT, outbox_q[0].id, 0, epoch_reg,
                     outbox_q[0].seq + 32'd1, 0);
        send_request(rds_pkg::FUNC_RECEIPT, outbox_q[0].id + 32'd1, 0, epoch_reg,
                     outbox_q[0].seq, 0);
        send_request(rds_pkg::FUNC_RECEIPT, outbox_q[0].id, 0, epoch_reg, outbox_q[0].seq, 0);
    endtask

    task automatic test_cancel();
        send_request(rds_pkg::FUNC_CANCEL, 32'h1234_5678, 0, 0, 0, 0);
        send_request(rds_pkg::FUNC_CANCEL, 32'h3, 0, 0, 0, 0);
        send_request(rds_pkg::FUNC_CANCEL_ALL, 0, 0, 0, 0, 0);
        send_request(rds_pkg::FUNC_CANCEL, 32'h0, 0, 0, 0, 0);
        // receipt against an empty outbox
        send_request(rds_pkg::FUNC_RECEIPT, 0, 0, epoch_reg, 0, 0);
        // cancel of a msg_id of zero that is present
        send_request(rds_pkg::FUNC_SUBMIT, 32'h0, 32'h9, 0, 0, 32'h9);
        send_request(rds_pkg::FUNC_CANCEL, 32'h0, 0, 0, 0, 0);
    endtask

    task automatic test_data();
        send_request(rds_pkg::FUNC_DATA, 32'hA, 32'h1, 64'h1, 32'd5, 0);
        send_request(rds_pkg::FUNC_DATA, 32'hB, 32'h1, 64'h1, 32'd5, 0);
        send_request(rds_pkg::FUNC_DATA, 32'hC, 32'h1, 64'h1, 32'd4, 0);
        send_request(rds_pkg::FUNC_DATA, 32'hD, 32'h1, 64'h1, 32'd6, 0);
        send_request(rds_pkg::FUNC_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1);
        send_request(rds_pkg::FUNC_DATA, 32'h0, 32'h0, '0, '0, '0);
    endtask

    task automatic test_unused_func();
        for (int f = FUNC_UNUSED; f <= 7; f++)
            send_request(3'(f), rand_word32(), rand_word32(), rand_word64(), rand_word32(),
                         rand_word32());
    endtask

    task automatic test_epoch_settings();
        write_epoch(64'h0);
        send_request(rds_pkg::FUNC_SUBMIT, 32'h77, 32'h1, 0, 0, 32'h1);
        send_request(rds_pkg::FUNC_RECEIPT, 32'h77, 0, 64'h0,
                     outbox_q[outbox_q.size()-1].seq, 0);
        send_request(rds_pkg::FUNC_CANCEL_ALL, 0, 0, 0, 0, 0);
        write_epoch(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(rds_pkg::FUNC_SUBMIT, 32'h78, 32'h1, 0, 0, 32'h1);
        send_request(rds_pkg::FUNC_RECEIPT, 32'h78, 0, '1, outbox_q[0].seq, 0);
        write_epoch(rand_word64());
    endtask

    // One random request, mostly well formed against the predictor state
    task automatic random_request();
        int          r;
        logic [31:0] id;
        logic [31:0] peer;
        logic [63:0] ep;
        logic [31:0] sq;
        logic [31:0] dig;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? rand_word32() : $urandom_range(0, 15);
        peer = ($urandom_range(0, 9) == 0) ? rand_word32() : $urandom_range(0, 3);
        dig = ($urandom_range(0, 9) == 0) ? rand_word32() : $urandom_range(0, 1);
        ep = ($urandom_range(0, 9) == 0) ? rand_word64() : 64'($urandom_range(0, 4));
        sq = ($urandom_range(0, 9) == 0) ? rand_word32() : $urandom_range(0, 60);
        if (r < 35)
            send_request(rds_pkg::FUNC_SUBMIT, id, peer, ep, sq, dig);
        else if (r < 60)
        begin
            if (outbox_q.size() > 0 && $urandom_range(0, 3) != 0)
                send_request(rds_pkg::FUNC_RECEIPT, outbox_q[0].id, peer, epoch_reg,
                             outbox_q[0].seq, dig);
            else
                send_request(rds_pkg::FUNC_RECEIPT, id, peer, ep, sq, dig);
        end
        else if (r < 85)
            send_request(rds_pkg::FUNC_DATA, rand_word32(), peer, ep, sq, dig);
        else if (r < 93)
        begin
            if (outbox_q.size() > 0 && $urandom_range(0, 1) == 0)
                id = outbox_q[$urandom_range(0, outbox_q.size() - 1)].id;
            send_request(rds_pkg::FUNC_CANCEL, id, peer, ep, sq, dig);
        end
        else if (r < 96)
            send_request(rds_pkg::FUNC_CANCEL_ALL, id, peer, ep, sq, dig);
        else
            send_request(3'($urandom_range(FUNC_UNUSED, 7)), id, peer, ep, sq, dig);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            no_idle = (i % 300) >= 250;
            random_request();
        end
        no_idle = 0;
    endtask

    // Hold the receiver off so the block fills and stalls its input
    task automatic test_backpressure();
        drain();
        hold_cnt = 400;
        for (int i = 0; i < 40; i++)
            random_request();
    endtask

    // Fill the dedupe table with new senders until it refuses them
    task automatic test_dedupe_full();
        for (int i = 0; i < SEEN_N + 4; i++)
            send_request(rds_pkg::FUNC_DATA, i, 32'h8000_0000 + i, 64'h55, 32'd1, 0);
        send_request(rds_pkg::FUNC_DATA, 32'h1, 32'h8000_0000, 64'h55, 32'd2, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        push = 1'b0;
        pop = 1'b0;
        func = '0;
        msg_id = '0;
        peer_node = '0;
        frame_epoch = '0;
        frame_seq = '0;
        content_digest = '0;
        error_count = 0;
        cycle_count = 0;
        hold_cnt = 0;
        pop_stall = 0;
        no_idle = 0;
        seq_counter = 32'd1;
        epoch_reg = rds_pkg::LOCAL_EPOCH_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_submit();
        test_receipt();
        test_cancel();
        test_data();
        test_unused_func();
        test_epoch_settings();
        test_random(400);
        write_epoch(64'h1);
        test_backpressure();
        test_random(400);
        write_epoch(rand_word64());
        test_random(300);
        test_dedupe_full();
        test_random(100);

        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
